@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and helpers for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;
    localparam int CELLS     = COLUMNS * ROWS;

    // field widths fixed by the stream payload
    localparam int ADDR_W = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CNT_W  = $clog2(TAB_WIDTH + 1);

    // request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // special characters
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] ATTR_RESET = 8'd15;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PUT    = 6'b000010,
        S_SCROLL = 6'b000100,
        S_FILL   = 6'b001000,
        S_RDWAIT = 6'b010000,
        S_OUT    = 6'b100000
    } tcw_state_t;

    // linear cell offset of a row/column pair
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row * COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

@@ hdl/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// Sequence: a put runs S_PUT then S_OUT and an in-range read S_RDWAIT then S_OUT before the
// result register; unused codes and out-of-range reads go straight to S_OUT; a tab repeats S_PUT
// for TAB_WIDTH spaces; clear writes every cell in S_FILL, then goes to S_OUT.
// Handshake: one request at a time; s_tready is high only while the sequencer idles.
// A put that scrolls adds a copy pass (S_SCROLL) and a fill of the bottom row (S_FILL),
// both run one cell at a time over the single read and single write port of the screen memory.
// Reset (aresetn low, synchronous): cursor to 0/0, attribute to 15, no result pending.
// ---------------------------------------------------------------------------
// text_console_writer_core
// Text screen of character/attribute cells with cursor, scroll, clear and
// cell read, driven by a small sequencer over one screen memory.
// ---------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // config: attribute byte
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // request beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // req_type[1:0], char_code[9:2], cell_index[20:10], pad
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // cursor_row[4:0], cursor_col[11:5],
                                    // cursor_offset[22:12], read_char[30:23],
                                    // read_attr[38:31], pad
);

    // -----------------------------------------------------------------
    // input field split
    // -----------------------------------------------------------------
    logic [1:0]        in_req;
    logic [7:0]        in_char;
    logic [ADDR_W-1:0] in_idx;
    logic              in_beat;

    assign in_req  = s_tdata[1:0];
    assign in_char = s_tdata[9:2];
    assign in_idx  = s_tdata[20:10];
    assign in_beat = s_tvalid && s_tready;

    // -----------------------------------------------------------------
    // state
    // -----------------------------------------------------------------
    tcw_state_t        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        attr_reg, attr_next;
    logic [7:0]        ch_reg, ch_next;          // character being put
    logic [CNT_W-1:0]  cnt_reg, cnt_next;        // puts left, current included
    logic [ADDR_W-1:0] scan_reg, scan_next;      // copy/fill destination
    logic              pend_reg, pend_next;      // copy read in flight
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        rc_reg, rc_next;
    logic [7:0]        ra_reg, ra_next;
    logic              m_valid_reg, m_valid_next;
    logic [39:0]       m_data_reg, m_data_next;

    // screen memory, one write and one registered read port
    logic [15:0]       screen_mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= screen_mem[mem_raddr];
    end

    // -----------------------------------------------------------------
    // single put step: cursor move plus at most one cell write
    // -----------------------------------------------------------------
    logic [ROW_W:0]    put_row;      // one extra bit to see the bottom overflow
    logic [COL_W-1:0]  put_col;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [7:0]        put_char;
    logic              put_scroll;

    always_comb begin
        put_row  = {1'b0, row_reg};
        put_col  = col_reg;
        put_we   = 1'b0;
        put_addr = cell_addr(row_reg, col_reg);
        put_char = ch_reg;
        priority if (ch_reg == CH_NL) begin
            put_row = {1'b0, row_reg} + 1'b1;
            put_col = '0;
        end else if (ch_reg == CH_BS) begin
            // backspace wraps to the end of the row above, stops at the top row
            if (col_reg == '0) begin
                put_col = COL_W'(COLUMNS - 1);
                if (row_reg != '0) begin
                    put_row = {1'b0, row_reg} - 1'b1;
                end
            end else begin
                put_col = col_reg - 1'b1;
            end
            put_we   = 1'b1;
            put_addr = cell_addr(put_row[ROW_W-1:0], put_col);
            put_char = CH_NUL;
        end else begin
            put_we = 1'b1;
            if (col_reg == COL_W'(COLUMNS - 1)) begin
                put_col = '0;
                put_row = {1'b0, row_reg} + 1'b1;
            end else begin
                put_col = col_reg + 1'b1;
            end
        end
        put_scroll = (put_row == (ROW_W + 1)'(ROWS));
    end

    // -----------------------------------------------------------------
    // sequencer
    // -----------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        attr_next      = attr_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        rc_next        = rc_reg;
        ra_next        = ra_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_reg;
        mem_wdata      = {attr_reg, CH_SPACE};
        mem_raddr      = in_idx;

        if (cfg_wr_en) begin
            attr_next = cfg_wr_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    rc_next = '0;
                    ra_next = '0;
                    unique case (in_req)
                        REQ_PUT: begin
                            // tab expands to a run of spaces
                            if (in_char == CH_TAB) begin
                                ch_next  = CH_SPACE;
                                cnt_next = CNT_W'(TAB_WIDTH);
                            end else begin
                                ch_next  = in_char;
                                cnt_next = CNT_W'(1);
                            end
                            state_next = S_PUT;
                        end
                        REQ_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            scan_next  = '0;
                            state_next = S_FILL;
                        end
                        REQ_READ: begin
                            // memory read issued on this edge
                            if (in_idx < ADDR_W'(CELLS)) begin
                                state_next = S_RDWAIT;
                            end else begin
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_PUT: begin
                mem_we    = put_we;
                mem_waddr = put_addr;
                mem_wdata = {attr_reg, put_char};
                col_next  = put_col;
                cnt_next  = cnt_reg - 1'b1;
                if (put_scroll) begin
                    row_next   = ROW_W'(ROWS - 1);
                    scan_next  = '0;
                    state_next = S_SCROLL;
                end else begin
                    row_next = put_row[ROW_W-1:0];
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = S_OUT;
                    end
                end
            end

            S_SCROLL: begin
                // read one row down, write the previous read one row up
                mem_raddr = scan_reg + ADDR_W'(COLUMNS);
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = mem_rdata_reg;
                if (scan_reg == ADDR_W'(CELLS - COLUMNS)) begin
                    state_next = S_FILL;
                end else begin
                    pend_next      = 1'b1;
                    pend_addr_next = scan_reg;
                    scan_next      = scan_reg + 1'b1;
                end
            end

            S_FILL: begin
                mem_we = 1'b1;
                if (scan_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = (cnt_reg != '0) ? S_PUT : S_OUT;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_RDWAIT: begin
                rc_next    = mem_rdata_reg[7:0];
                ra_next    = mem_rdata_reg[15:8];
                state_next = S_OUT;
            end

            S_OUT: begin
                // wait for a free output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, ra_reg, rc_reg,
                                    cell_addr(row_reg, col_reg), col_reg, row_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            attr_reg    <= ATTR_RESET;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            attr_reg    <= attr_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        ch_reg        <= ch_next;
        scan_reg      <= scan_next;
        pend_addr_reg <= pend_addr_next;
        rc_reg        <= rc_next;
        ra_reg        <= ra_next;
        m_data_reg    <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ hdl/tcw_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ---------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [7:0]  cfg_wr_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one request at a time: busy right after a request beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[11:5]) < COLUMNS) && (int'(m_tdata[4:0]) < ROWS))
        else $error("cursor off screen");

    // offset agrees with row and column
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> int'(m_tdata[22:12]) == int'(m_tdata[4:0]) * COLUMNS
                                              + int'(m_tdata[11:5]))
        else $error("cursor offset mismatch");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

@@ bench/text_console_writer_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer. Request beats come from a
// queue that the stimulus process fills phase by phase; each accepted request
// runs through a behavioral screen/cursor model, and every result beat is
// checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module text_console_writer_core_tb;
    import tcw_pkg::*;

    // request code 3 is not decoded by the block; it must answer with the cursor only
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // two copies of the console model: PLAN runs at queue time so that reads
    // only target cells that will hold data; LIVE runs at beat acceptance
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    // longest silent stretch is a clear or a scrolling tab plus
    // a receiver stall; allow generous headroom
    localparam int IDLE_LIMIT  = 20000;
    localparam int PHASE_BEATS = 108;

    // request beat payload, highest field first in the packed order below
    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [7:0]        ch;
        logic [1:0]        kind;
    } console_req_t;

    // result beat payload
    typedef struct packed {
        logic [7:0]        rattr;
        logic [7:0]        rch;
        logic [ADDR_W-1:0] offs;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } cursor_rpt_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_TOGGLE} rx_mode_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = 24'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;

    text_console_writer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Console model state (screen, per-cell written flag, cursor, attribute)
    // -----------------------------------------------------------------------
    logic [15:0] screen   [2][CELLS];
    bit          written  [2][CELLS];
    int          cur_row  [2];
    int          cur_col  [2];
    logic [7:0]  attr_reg [2];

    console_req_t req_fifo [$];     // requests waiting for the driver
    cursor_rpt_t  rpt_q    [$];     // predicted results, oldest first

    int queued_cnt   = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int mismatch_cnt = 0;
    int scroll_cnt   = 0;
    int wrap_cnt     = 0;
    int clear_cnt    = 0;
    int read_hits    = 0;
    int tab_cnt      = 0;

    function automatic void store_cell(input int k, input logic [7:0] ch);
        int pos;
        pos = cur_row[k] * COLUMNS + cur_col[k];
        screen[k][pos]  = {attr_reg[k], ch};
        written[k][pos] = 1'b1;
    endfunction

    // column wrap, then scroll up one row once the cursor falls off the bottom;
    // the freshly exposed bottom row is blanked with spaces
    function automatic void wrap_and_scroll(input int k);
        if (cur_col[k] >= COLUMNS) begin
            cur_col[k] = 0;
            cur_row[k]++;
            if (k == LIVE) wrap_cnt++;
        end
        if (cur_row[k] >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
                screen[k][i]  = screen[k][i + COLUMNS];
                written[k][i] = written[k][i + COLUMNS];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                screen[k][i]  = {attr_reg[k], CH_SPACE};
                written[k][i] = 1'b1;
            end
            cur_row[k] = ROWS - 1;
            if (k == LIVE) scroll_cnt++;
        end
    endfunction

    function automatic void put_glyph(input int k, input logic [7:0] ch);
        if (ch == CH_NL) begin
            cur_row[k]++;
            cur_col[k] = 0;
        end else if (ch == CH_BS) begin
            // backspace at column 0 backs up to the end of the row above
            if (cur_col[k] == 0) begin
                if (cur_row[k] > 0) cur_row[k]--;
                cur_col[k] = COLUMNS - 1;
            end else begin
                cur_col[k]--;
            end
            store_cell(k, CH_NUL);
        end else begin
            store_cell(k, ch);
            cur_col[k]++;
        end
        wrap_and_scroll(k);
    endfunction

    function automatic cursor_rpt_t console_step(input int k, input console_req_t r);
        cursor_rpt_t rpt;
        logic [7:0]  rc;
        logic [7:0]  ra;
        rc = 8'd0;
        ra = 8'd0;
        case (r.kind)
            REQ_PUT: begin
                if (r.ch == CH_TAB) begin
                    repeat (TAB_WIDTH) put_glyph(k, CH_SPACE);
                    if (k == LIVE) tab_cnt++;
                end else begin
                    put_glyph(k, r.ch);
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[k][i]  = {attr_reg[k], CH_SPACE};
                    written[k][i] = 1'b1;
                end
                cur_row[k] = 0;
                cur_col[k] = 0;
                if (k == LIVE) clear_cnt++;
            end
            REQ_READ: begin
                if (r.idx < CELLS) begin
                    rc = screen[k][r.idx][7:0];
                    ra = screen[k][r.idx][15:8];
                    if (k == LIVE) read_hits++;
                end
            end
            default: ;
        endcase
        rpt.row   = ROW_W'(cur_row[k]);
        rpt.col   = COL_W'(cur_col[k]);
        rpt.offs  = ADDR_W'(cur_row[k] * COLUMNS + cur_col[k]);
        rpt.rch   = rc;
        rpt.rattr = ra;
        return rpt;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [ADDR_W-1:0] idx);
        console_req_t r;
        r.kind = kind;
        r.ch   = ch;
        r.idx  = idx;
        void'(console_step(PLAN, r));
        req_fifo.push_back(r);
        queued_cnt++;
    endtask

    function automatic logic [ADDR_W-1:0] any_index();
        return ADDR_W'($urandom);
    endfunction

    // in-range reads only hit cells the plan knows to be written; otherwise
    // the read goes past the screen
    function automatic logic [ADDR_W-1:0] read_index();
        int i;
        if ($urandom_range(0, 6) == 0)
            return ADDR_W'($urandom_range(CELLS, 2**ADDR_W - 1));
        repeat (16) begin
            i = $urandom_range(0, CELLS - 1);
            if (written[PLAN][i]) return ADDR_W'(i);
        end
        return ADDR_W'($urandom_range(CELLS, 2**ADDR_W - 1));
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom);
    endfunction

    // random phase built from short runs: text, line feeds, backspaces, tabs,
    // read probes, with rare clears, unused codes and raw noise
    task automatic queue_random_phase(input int target);
        int stop_at;
        int pick;
        int len;
        logic [1:0] kind;
        stop_at = queued_cnt + target;
        while (queued_cnt < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = $urandom_range(1, 60);
                repeat (len) queue_req(REQ_PUT, text_byte(), any_index());
            end else if (pick < 55) begin
                len = $urandom_range(1, 30);
                repeat (len) queue_req(REQ_PUT, CH_NL, any_index());
            end else if (pick < 65) begin
                len = $urandom_range(1, 6);
                repeat (len) queue_req(REQ_PUT, CH_BS, any_index());
            end else if (pick < 72) begin
                len = $urandom_range(1, 8);
                repeat (len) queue_req(REQ_PUT, CH_TAB, any_index());
            end else if (pick < 92) begin
                len = $urandom_range(1, 4);
                repeat (len) queue_req(REQ_READ, 8'($urandom), read_index());
            end else if (pick < 95) begin
                queue_req(REQ_CLEAR, 8'($urandom), any_index());
            end else if (pick < 98) begin
                queue_req(REQ_UNUSED, 8'($urandom), any_index());
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) begin
                    kind = 2'($urandom_range(0, 3));
                    queue_req(kind, 8'($urandom),
                              (kind == REQ_READ) ? read_index() : any_index());
                end
            end
        end
    endtask

    // every queued request accepted and every prediction matched by a beat
    task automatic wait_drained();
        while (beats_in < queued_cnt || rpt_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // attribute register: only touched while the block sits idle
    task automatic set_attribute(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_reg[PLAN] = v;
        attr_reg[LIVE] = v;
    endtask

    // -----------------------------------------------------------------------
    // Stimulus sequencing
    // -----------------------------------------------------------------------
    initial begin
        attr_reg[PLAN] = ATTR_RESET;
        attr_reg[LIVE] = ATTR_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every request code, the special characters,
        // backspace wrap to the row above and at the top-left, row wrap,
        // out-of-range reads; runs on the reset attribute
        queue_req(REQ_PUT,    8'h48,    11'd0);
        queue_req(REQ_PUT,    8'h00,    11'd0);
        queue_req(REQ_PUT,    8'hFF,    11'h7FF);
        queue_req(REQ_READ,   8'h00,    11'd0);
        queue_req(REQ_READ,   8'hFF,    11'd2);
        queue_req(REQ_READ,   8'h00,    11'h7FF);
        queue_req(REQ_READ,   8'h00,    ADDR_W'(CELLS));
        queue_req(REQ_UNUSED, 8'hFF,    11'h7FF);
        queue_req(REQ_PUT,    CH_BS,    11'd0);
        queue_req(REQ_READ,   8'h00,    11'd2);
        queue_req(REQ_PUT,    CH_TAB,   11'd0);
        queue_req(REQ_READ,   8'h00,    11'd5);
        queue_req(REQ_PUT,    CH_NL,    11'd0);
        queue_req(REQ_PUT,    CH_BS,    11'd0);    // column 0 -> end of row above
        queue_req(REQ_READ,   8'h00,    ADDR_W'(COLUMNS - 1));
        queue_req(REQ_PUT,    CH_NL,    11'd0);
        queue_req(REQ_CLEAR,  8'h00,    11'd0);
        queue_req(REQ_PUT,    CH_BS,    11'd0);    // top-left stays on row 0
        queue_req(REQ_READ,   8'h00,    ADDR_W'(CELLS - 1));
        queue_req(REQ_PUT,    8'h5A,    11'd0);    // last column, wraps
        queue_req(REQ_READ,   8'h00,    ADDR_W'(COLUMNS - 1));
        queue_req(REQ_READ,   8'h00,    11'h555);
        wait_drained();

        // random phases, attribute swept through both extremes and two randoms;
        // each boundary drains every pending result first
        set_attribute(8'h00);
        queue_random_phase(PHASE_BEATS);
        wait_drained();
        set_attribute(8'hFF);
        queue_random_phase(PHASE_BEATS);
        wait_drained();
        set_attribute(8'($urandom));
        queue_random_phase(PHASE_BEATS);
        wait_drained();
        set_attribute(8'($urandom));
        queue_random_phase(PHASE_BEATS);
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Ran %0d requests / %0d results: %0d scrolls, %0d row wraps, %0d clears,",
                 beats_in, beats_out, scroll_cnt, wrap_cnt, clear_cnt);
        $display("  %0d in-range cell reads, %0d tabs, %0d mismatches",
                 read_hits, tab_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && rpt_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // -----------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps in between.
    // The model is stepped at the accepting edge, so its attribute is the one
    // the block holds for that request.
    // -----------------------------------------------------------------------
    console_req_t req_on_bus;
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rpt_q.push_back(console_step(LIVE, req_on_bus));
                beats_in++;
            end
            // next beat only once the current one is gone
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_fifo.size() != 0) begin
                    req_on_bus = req_fifo.pop_front();
                    s_tdata  <= {3'b000, req_on_bus};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // about a quarter of bursts run straight on with no gap
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor and receiver backpressure
    // -----------------------------------------------------------------------
    rx_mode_t    rx_mode   = RX_OPEN;
    int          mode_left = 0;
    cursor_rpt_t got;
    cursor_rpt_t want;

    function automatic void flag_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $realtime, name, exp_v, act_v);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                got = cursor_rpt_t'(m_tdata[38:0]);
                if (rpt_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result beat 0x%0h with nothing pending",
                                 $realtime, m_tdata);
                end else begin
                    want = rpt_q.pop_front();
                    if (got.row !== want.row)
                        flag_field("cursor_row", 16'(want.row), 16'(got.row));
                    if (got.col !== want.col)
                        flag_field("cursor_col", 16'(want.col), 16'(got.col));
                    if (got.offs !== want.offs)
                        flag_field("cursor_offset", 16'(want.offs), 16'(got.offs));
                    if (got.rch !== want.rch)
                        flag_field("read_char", 16'(want.rch), 16'(got.rch));
                    if (got.rattr !== want.rattr)
                        flag_field("read_attr", 16'(want.rattr), 16'(got.rattr));
                end
            end
            // stall pattern switches between open, coin-flip, tight and toggle
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN:  m_tready <= 1'b1;
                RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                RX_TIGHT: m_tready <= ($urandom_range(0, 3) == 0);
                default:  m_tready <= ~m_tready;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: cycles without any accepted beat on either side
    // -----------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles, %0d results pending",
                         IDLE_LIMIT, rpt_q.size());
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
